// ----- hw/rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants of the integer-to-ASCII formatter
// Command and status bundles between controller and datapath, op codes,
// character constants and the digit-to-glyph lookup.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // op codes of the input beat
  localparam logic OP_DEC = 1'b0;
  localparam logic OP_HEX = 1'b1;

  // ASCII codes
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;

  // hex mode looks at the low 32 bits only
  localparam int HEX_BITS = 32;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input beat
    logic dabble;      // two double-dabble steps (two bits)
    logic skip;        // drop a leading zero digit
    logic emit_sign;   // load '-' into the output register
    logic emit_digit;  // load the top digit into the output register
  } itoa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dab_done;    // conversion finished
    logic top_zero;    // top digit is zero
    logic one_left;    // a single digit remains
    logic neg;         // number is negative
    logic out_free;    // output register can take a beat this cycle
  } itoa_status_t;

  // digit value to lowercase ASCII glyph
  function automatic logic [7:0] itoa_glyph(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + {4'd0, d};
    end else begin
      c = CHAR_LC_A + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/integer_to_ascii_formatter_core.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core: binary number to ASCII characters
// Op 0 prints the low VALUE_WIDTH bits of the value as signed decimal, op 1
// prints the low 32 bits as lowercase hex, most significant character first.
// ----------------------------------------------------------------------------
// One number is handled at a time; in_stall is low only while the block is
// idle. Decimal conversion runs a double-dabble unit that consumes two bits
// per cycle: ceil(VALUE_WIDTH/2) steps (32 at the default), after which the
// controller sees the step count run out; hex needs no steps. Leading zero
// digits are then dropped one per cycle (up to NDIG-1 digits, NDIG = 19
// decimal digits at the default), the controller moves on to emission, and
// each character passes through the output register, which holds it while
// out_stall is high. Dropped and printed digits add up to NDIG. The final
// character of each number carries out_last; a negative decimal number
// starts with '-', zero prints as a single "0".
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [63:0] in_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_character,
  output logic        out_last
);

  itoa_cmd_t    cmd;
  itoa_status_t st;

  // sequencer
  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // conversion and output datapath
  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

// ----- hw/rtl/itoa_ctrl.sv -----
// ----------------------------------------------------------------------------
// itoa_ctrl: sequencing state machine of the formatter
// Walks one number through load, conversion, leading-zero skip, optional
// sign and per-character emission, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module itoa_ctrl
  import itoa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  itoa_status_t st,
  output itoa_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } itoa_state_t;

  itoa_state_t state_r, state_nxt;

  // only take a new number while idle
  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (st.dab_done) begin
          state_nxt = S_SKIP;
        end else begin
          cmd.dabble = 1'b1;
        end
      end
      S_SKIP: begin
        if (st.top_zero && !st.one_left) begin
          cmd.skip = 1'b1;
        end else if (st.neg) begin
          state_nxt = S_SIGN;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SIGN: begin
        if (st.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_digit = 1'b1;
          if (st.one_left) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/itoa_dp.sv -----
// ----------------------------------------------------------------------------
// itoa_dp: datapath of the formatter
// Sign handling, double-dabble binary-to-BCD conversion two bits per cycle,
// a digit shift register for skip and emission, and the output register.
// ----------------------------------------------------------------------------
module itoa_dp
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_op,
  input  logic [63:0]  in_value,
  input  logic         out_stall,
  output logic         out_valid,
  output logic [7:0]   out_character,
  output logic         out_last,
  input  itoa_cmd_t    cmd,
  output itoa_status_t st
);

  // digits of the largest magnitude 2^(VALUE_WIDTH-1)
  localparam int NDIG  = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;
  localparam int BW    = NDIG * 4;
  // binary width padded to an even count of bits
  localparam int PW    = VALUE_WIDTH + (VALUE_WIDTH % 2);
  localparam int STEPS = PW / 2;
  localparam int WW    = BW + PW;
  localparam int SCW   = $clog2(STEPS + 1);
  localparam int RCW   = $clog2(NDIG + 1);

  logic [BW-1:0]          bcd_r;
  logic [PW-1:0]          bin_r;
  logic [SCW-1:0]         step_cnt_r;
  logic [RCW-1:0]         remain_r;
  logic                   neg_r;
  logic                   out_valid_r;
  logic [7:0]             out_character_r;
  logic                   out_last_r;

  logic [VALUE_WIDTH-1:0] v;
  logic                   neg_w;
  logic [VALUE_WIDTH-1:0] mag;
  logic [WW-1:0]          work;
  logic [3:0]             top_digit;

  // sign and magnitude of the incoming beat
  assign v     = in_value[VALUE_WIDTH-1:0];
  assign neg_w = (in_op == OP_DEC) && v[VALUE_WIDTH-1];
  assign mag   = neg_w ? (~v + VALUE_WIDTH'(1)) : v;

  // two double-dabble steps: add 3 to digits >= 5, then shift left
  always_comb begin
    work = {bcd_r, bin_r};
    for (int s = 0; s < 2; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (work[PW+4*d +: 4] >= 4'd5) begin
          work[PW+4*d +: 4] = work[PW+4*d +: 4] + 4'd3;
        end
      end
      work = work << 1;
    end
  end

  assign top_digit = bcd_r[BW-1 -: 4];

  // status to the controller
  assign st.dab_done = (step_cnt_r == '0);
  assign st.top_zero = (top_digit == 4'd0);
  assign st.one_left = (remain_r == RCW'(1));
  assign st.neg      = neg_r;
  assign st.out_free = !out_valid_r || !out_stall;

  // conversion registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r    <= neg_w;
      remain_r <= RCW'(NDIG);
      if (in_op == OP_HEX) begin
        bcd_r      <= BW'(in_value[HEX_BITS-1:0]);
        bin_r      <= '0;
        step_cnt_r <= '0;
      end else begin
        bcd_r      <= '0;
        bin_r      <= PW'(mag);
        step_cnt_r <= SCW'(STEPS);
      end
    end else if (cmd.dabble) begin
      bcd_r      <= work[WW-1:PW];
      bin_r      <= work[PW-1:0];
      step_cnt_r <= step_cnt_r - SCW'(1);
    end else if (cmd.skip || cmd.emit_digit) begin
      bcd_r    <= bcd_r << 4;
      remain_r <= remain_r - RCW'(1);
    end
  end

  // output register: valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_character_r <= CHAR_MINUS;
      out_last_r      <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_character_r <= itoa_glyph(top_digit);
      out_last_r      <= st.one_left;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

`ifndef SYNTHESIS
  // a new beat never overwrites one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> (!out_valid_r || !out_stall))
    else $error("emit while output register is held");

  // skipping keeps at least one digit
  a_skip_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.skip |-> (remain_r > RCW'(1)) && (top_digit == 4'd0))
    else $error("skip of a significant or final digit");

  // hex numbers need no conversion steps
  a_hex_no_dabble: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && (in_op == OP_HEX)) |=> (step_cnt_r == '0))
    else $error("hex load left conversion steps pending");

  // the last digit is marked exactly when the count runs out
  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |=> (out_last_r == (remain_r == '0)))
    else $error("last flag out of step with digit count");
`endif

endmodule

// ----- tb/sv/integer_to_ascii_formatter_core_test.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_test: self-checking bench for the formatter
// Feeds decimal and hex numbers through the input channel in random bursts,
// predicts the character beats of every accepted number and checks each
// result beat against the oldest prediction under varying receiver stalls.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_core_test
  import itoa_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 120;
  localparam int RANDOM_COUNT = 150;
  localparam int REPORT_MAX   = 10;

  // receiver stall styles, rotated by bits 9:8 of the cycle count
  localparam logic [1:0] STALL_NONE  = 2'd0;
  localparam logic [1:0] STALL_LIGHT = 2'd1;
  localparam logic [1:0] STALL_HALF  = 2'd2;
  localparam logic [1:0] STALL_RUNS  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [63:0] value;
    logic        drain;   // wait for all characters before showing this one
  } number_beat_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_DEC;
  logic [63:0] in_value = 64'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_character;
  logic        out_last;

  number_beat_t numbers_to_send[$];
  char_beat_t   expected_chars[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_run = 0;
  logic         in_fire;
  logic         show_next;

  integer_to_ascii_formatter_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ASCII glyph of one digit
  function automatic logic [7:0] digit_char(input logic [63:0] d);
    logic [7:0] c;
    if (d < 64'd10) begin
      c = CHAR_ZERO + d[7:0];
    end else begin
      c = CHAR_LC_A + (d[7:0] - 8'd10);
    end
    return c;
  endfunction

  // characters of one number, most significant first
  function automatic void format_expected(input logic op, input logic [63:0] value);
    logic [63:0] mag;
    logic [63:0] radix;
    logic        neg;
    logic [7:0]  rev[$];
    char_beat_t  b;
    int          i;
    neg = 1'b0;
    if (op == OP_DEC) begin
      radix = 64'd10;
      if (value[63]) begin
        neg = 1'b1;
        mag = -value;     // also exact for the most negative value
      end else begin
        mag = value;
      end
    end else begin
      radix = 64'd16;
      mag = {32'd0, value[HEX_BITS-1:0]};
    end
    do begin
      rev.push_back(digit_char(mag % radix));
      mag = mag / radix;
    end while (mag != 64'd0);
    if (neg) begin
      b.character = CHAR_MINUS;
      b.last = 1'b0;
      expected_chars.push_back(b);
    end
    for (i = rev.size() - 1; i >= 0; i--) begin
      b.character = rev[i];
      b.last = (i == 0);
      expected_chars.push_back(b);
    end
  endfunction

  function automatic void add_number(input logic op, input logic [63:0] value,
                                     input logic drain);
    number_beat_t n;
    n.op = op;
    n.value = value;
    n.drain = drain;
    numbers_to_send.push_back(n);
  endfunction

  function automatic logic [63:0] power_of_ten(input int k);
    logic [63:0] p;
    int j;
    p = 64'd1;
    for (j = 0; j < k; j++) p = p * 64'd10;
    return p;
  endfunction

  // random number with a spread of lengths
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(0, 4))
      0: v = {$urandom, $urandom};
      1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      2: v = 64'($urandom_range(0, 20));
      3: v = power_of_ten($urandom_range(0, 19)) - 64'($urandom_range(0, 1));
      default: v = -({$urandom, $urandom} >> $urandom_range(0, 63));
    endcase
    if ($urandom_range(0, 3) == 0) v = -v;
    return v;
  endfunction

  // sender: bursts of beats with random gaps; payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      in_fire = in_valid && !in_stall;
      if (in_fire) begin
        format_expected(in_op, in_value);
        void'(numbers_to_send.pop_front());
      end
      if (!(in_valid && !in_fire)) begin
        show_next = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (numbers_to_send.size() > 0) begin
          if (numbers_to_send[0].drain && expected_chars.size() != 0) begin
            show_next = 1'b0;
          end else begin
            show_next = 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 8);
            burst_left--;
            if (burst_left == 0) begin
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            end
          end
        end
        in_valid <= show_next;
        if (show_next) begin
          in_op <= numbers_to_send[0].op;
          in_value <= numbers_to_send[0].value;
        end else begin
          in_op <= 1'($urandom_range(0, 1));
          in_value <= {$urandom, $urandom};
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else begin
      case (cycle_count[9:8])
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
        STALL_RUNS: begin
          if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
          end else begin
            if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
            out_stall <= 1'b0;
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    char_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected beat: character %h last %b", out_character, out_last);
        end
      end else begin
        want = expected_chars.pop_front();
        if (out_character !== want.character || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: character exp %h got %h, last exp %b got %b",
                     want.character, out_character, want.last, out_last);
          end
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_to_ascii_formatter_core regression: fail");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int k;
    // directed: zero, ones, limits, powers of ten, hex extremes
    add_number(OP_DEC, 64'd0, 1'b0);
    add_number(OP_DEC, 64'd1, 1'b0);
    add_number(OP_DEC, -64'd1, 1'b0);
    add_number(OP_DEC, 64'd9, 1'b0);
    add_number(OP_DEC, 64'd10, 1'b0);
    add_number(OP_DEC, -64'd10, 1'b0);
    add_number(OP_DEC, 64'h7fff_ffff_ffff_ffff, 1'b0);
    add_number(OP_DEC, 64'h8000_0000_0000_0000, 1'b0);
    add_number(OP_DEC, 64'h8000_0000_0000_0001, 1'b0);
    add_number(OP_DEC, power_of_ten(18), 1'b0);
    add_number(OP_DEC, power_of_ten(18) - 64'd1, 1'b0);
    add_number(OP_DEC, power_of_ten(19), 1'b0);
    add_number(OP_HEX, 64'd0, 1'b1);
    add_number(OP_HEX, 64'hdead_beef_0000_0000, 1'b0);
    add_number(OP_HEX, 64'h0000_0000_ffff_ffff, 1'b0);
    add_number(OP_HEX, 64'hffff_ffff_ffff_ffff, 1'b0);
    add_number(OP_HEX, 64'h0000_0000_0123_abcd, 1'b0);
    add_number(OP_HEX, 64'h0000_0000_8000_0000, 1'b0);
    add_number(OP_HEX, 64'h0000_0000_0000_000a, 1'b0);
    add_number(OP_HEX, 64'h5555_5555_9876_fedc, 1'b0);
    add_number(OP_DEC, 64'hffff_ffff_ffff_fff6, 1'b1);
    // random numbers, now and then after a full drain
    for (k = 0; k < RANDOM_COUNT; k++) begin
      add_number(1'($urandom_range(0, 1)), random_value(), ($urandom_range(0, 39) == 0));
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (numbers_to_send.size() != 0) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("integer_to_ascii_formatter_core regression: pass");
    end else begin
      $display("integer_to_ascii_formatter_core regression: fail");
    end
    $finish;
  end

endmodule
